FILE: hdl/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg
// Shared codes, widths and types for the clause assignment reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package car_pkg;

    localparam int VAR_W   = 10;
    localparam int LIT_W   = VAR_W + 1;
    localparam int EPOCH_W = 4;
    localparam int CNT_W   = 7;
    localparam int TDATA_W = 16;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ASSIGN  = 2'd1;
    localparam logic [1:0] ACT_LITERAL = 2'd2;

    localparam logic [1:0] KIND_KEPT     = 2'd0;
    localparam logic [1:0] KIND_CONFLICT = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] count;
        logic             bank;
    } car_desc_t;

endpackage

`default_nettype wire

FILE: hdl/car_queue.sv
// ----------------------------------------------------------------------------
// car_queue
// Two-entry descriptor queue between the clause front end and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module car_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  wire car_pkg::car_desc_t din,
    input  wire                     pop,
    output car_pkg::car_desc_t      dout,
    output logic                    empty,
    output logic                    full
);

    car_pkg::car_desc_t slot_reg [0:1];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign dout  = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = ~wptr_reg;
        end
        if (pop) begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= din;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && full) |-> pop)
        else $error("descriptor queue overrun");

endmodule

`default_nettype wire

FILE: hdl/car_front.sv
// ----------------------------------------------------------------------------
// car_front
// Accepts items, keeps the assignment store and classifies clause literals.
// ----------------------------------------------------------------------------
`default_nettype none

module car_front #(
    parameter int NUM_VARS       = 1024,
    parameter int MAX_CLAUSE_LEN = 32,
    parameter int IW             = $clog2(MAX_CLAUSE_LEN)
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire  [1:0]                 action,
    input  wire  [car_pkg::VAR_W-1:0]  variable,
    input  wire                        polarity,
    input  wire                        last,
    output logic                       buf_we,
    output logic [IW:0]                buf_addr,
    output logic [car_pkg::LIT_W-1:0]  buf_data,
    output logic                       push,
    output car_pkg::car_desc_t         desc,
    input  wire                        free_valid,
    input  wire                        free_bank
);

    localparam int AW      = $clog2(NUM_VARS);
    localparam int CW      = $clog2(MAX_CLAUSE_LEN + 1);
    localparam int ENTRY_W = car_pkg::EPOCH_W + 2;
    localparam logic [AW-1:0] SWEEP_LAST = AW'(NUM_VARS - 1);
    localparam logic [16:0]   NV_LIMIT   = 17'(NUM_VARS);
    localparam logic [CW-1:0] KEEP_MAX   = CW'(MAX_CLAUSE_LEN);

    logic [ENTRY_W-1:0] store_mem [0:NUM_VARS-1];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic                         sweep_reg, sweep_next;
    logic [AW-1:0]                sweep_addr_reg, sweep_addr_next;
    logic [car_pkg::EPOCH_W-1:0]  epoch_reg, epoch_next;

    logic                         s1_valid_reg, s1_valid_next;
    logic [1:0]                   s1_action_reg;
    logic [car_pkg::VAR_W-1:0]    s1_var_reg;
    logic                         s1_pol_reg;
    logic                         s1_last_reg;
    logic                         s1_inrange_reg;

    logic [CW-1:0] kept_reg, kept_next;
    logic          sat_reg, sat_next;
    logic          ovf_reg, ovf_next;
    logic          conflict_reg, conflict_next;
    logic          wbank_reg, wbank_next;
    logic [1:0]    busy_reg, busy_next;

    logic accept, in_range, s1_is_lit, s1_go, lit_step, clr_step, hit;
    logic [CW-1:0] kept_end;

    assign in_range  = (17'(variable) < NV_LIMIT);
    assign s1_is_lit = s1_valid_reg && (s1_action_reg == car_pkg::ACT_LITERAL) && !conflict_reg;
    assign s1_go     = !s1_is_lit || !busy_reg[wbank_reg];
    assign s_tready  = !sweep_reg && (!s1_valid_reg || s1_go);
    assign accept    = s_tvalid && s_tready;
    assign lit_step  = s1_is_lit && s1_go;
    assign clr_step  = s1_valid_reg && (s1_action_reg == car_pkg::ACT_CLEAR);

    assign hit = s1_inrange_reg && rd_data_reg[1]
                 && (rd_data_reg[ENTRY_W-1:2] == epoch_reg);

    assign buf_addr = {wbank_reg, kept_reg[IW-1:0]};
    assign buf_data = {s1_pol_reg, s1_var_reg};

    // assignment store, cleared lazily by epoch with a sweep after reset and on wrap
    always_ff @(posedge aclk) begin
        if (sweep_reg) begin
            store_mem[sweep_addr_reg] <= '0;
        end else if (accept && (action == car_pkg::ACT_ASSIGN) && in_range) begin
            store_mem[AW'(variable)] <= {epoch_reg, 1'b1, polarity};
        end
        if (accept) begin
            rd_data_reg <= store_mem[AW'(variable)];
        end
    end

    always_comb begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        epoch_next      = epoch_reg;
        if (sweep_reg) begin
            sweep_addr_next = sweep_addr_reg + AW'(1);
            if (sweep_addr_reg == SWEEP_LAST) begin
                sweep_next      = 1'b0;
                sweep_addr_next = '0;
            end
        end else if (accept && (action == car_pkg::ACT_CLEAR)) begin
            if (epoch_reg == '1) begin
                sweep_next = 1'b1;
                epoch_next = '0;
            end else begin
                epoch_next = epoch_reg + car_pkg::EPOCH_W'(1);
            end
        end
    end

    always_comb begin
        kept_next     = kept_reg;
        sat_next      = sat_reg;
        ovf_next      = ovf_reg;
        conflict_next = conflict_reg;
        wbank_next    = wbank_reg;
        busy_next     = busy_reg;
        buf_we        = 1'b0;
        push          = 1'b0;
        kept_end      = kept_reg;
        desc.kind     = car_pkg::KIND_KEPT;
        desc.count    = '0;
        desc.bank     = wbank_reg;

        if (free_valid) begin
            busy_next[free_bank] = 1'b0;
        end

        if (lit_step && !sat_reg) begin
            if (hit) begin
                if (rd_data_reg[0] == s1_pol_reg) begin
                    sat_next = 1'b1;
                end
            end else if (kept_reg < KEEP_MAX) begin
                buf_we    = 1'b1;
                kept_next = kept_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        kept_end = kept_next;

        if (lit_step && s1_last_reg) begin
            if (!sat_next) begin
                push       = 1'b1;
                desc.count = car_pkg::CNT_W'(kept_end);
                if (ovf_next) begin
                    desc.kind = car_pkg::KIND_OVERFLOW;
                end else if (kept_end == '0) begin
                    desc.kind     = car_pkg::KIND_CONFLICT;
                    conflict_next = 1'b1;
                end
                wbank_next           = ~wbank_reg;
                busy_next[wbank_reg] = 1'b1;
            end
            kept_next = '0;
            sat_next  = 1'b0;
            ovf_next  = 1'b0;
        end

        if (clr_step) begin
            kept_next     = '0;
            sat_next      = 1'b0;
            ovf_next      = 1'b0;
            conflict_next = 1'b0;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            epoch_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            kept_reg       <= '0;
            sat_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            conflict_reg   <= 1'b0;
            wbank_reg      <= 1'b0;
            busy_reg       <= 2'b00;
        end else begin
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            epoch_reg      <= epoch_next;
            s1_valid_reg   <= s1_valid_next;
            kept_reg       <= kept_next;
            sat_reg        <= sat_next;
            ovf_reg        <= ovf_next;
            conflict_reg   <= conflict_next;
            wbank_reg      <= wbank_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_action_reg  <= action;
            s1_var_reg     <= variable;
            s1_pol_reg     <= polarity;
            s1_last_reg    <= last;
            s1_inrange_reg <= in_range;
        end
    end

    a_write_free_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        (buf_we || push) |-> !busy_reg[wbank_reg])
        else $error("clause buffer bank written while still being emitted");

    a_conflict_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (desc.kind == car_pkg::KIND_CONFLICT)) |=> conflict_reg)
        else $error("conflict flag not set after empty clause");

endmodule

`default_nettype wire

FILE: hdl/car_back.sv
// ----------------------------------------------------------------------------
// car_back
// Double-banked clause buffer and result emitter with registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module car_back #(
    parameter int MAX_CLAUSE_LEN = 32,
    parameter int IW             = $clog2(MAX_CLAUSE_LEN)
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        buf_we,
    input  wire  [IW:0]                buf_addr,
    input  wire  [car_pkg::LIT_W-1:0]  buf_data,
    input  wire car_pkg::car_desc_t    q_dout,
    input  wire                        q_empty,
    output logic                       q_pop,
    output logic                       free_valid,
    output logic                       free_bank,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    output logic [1:0]                 kind,
    output logic [car_pkg::VAR_W-1:0]  out_variable,
    output logic                       out_polarity,
    output logic                       end_of_clause
);

    localparam int DEPTH = 2 * (2 ** IW);
    localparam logic B_IDLE = 1'b0;
    localparam logic B_SEND = 1'b1;

    logic [car_pkg::LIT_W-1:0] buf_mem [0:DEPTH-1];
    logic [car_pkg::LIT_W-1:0] lit_reg;

    logic                      state_reg, state_next;
    logic [1:0]                kind_reg;
    logic [car_pkg::CNT_W-1:0] count_reg;
    logic                      bank_reg;
    logic [IW-1:0]             idx_reg;

    logic          is_kept, xfer, rd_en;
    logic [IW:0]   rd_addr;

    assign is_kept       = (kind_reg == car_pkg::KIND_KEPT);
    assign m_tvalid      = (state_reg == B_SEND);
    assign kind          = kind_reg;
    assign out_variable  = is_kept ? lit_reg[car_pkg::VAR_W-1:0] : '0;
    assign out_polarity  = is_kept ? lit_reg[car_pkg::VAR_W] : 1'b0;
    assign end_of_clause = !is_kept
                           || ((car_pkg::CNT_W'(idx_reg) + car_pkg::CNT_W'(1)) == count_reg);
    assign xfer          = m_tvalid && m_tready;
    assign q_pop         = (state_reg == B_IDLE) && !q_empty;
    assign free_valid    = xfer && end_of_clause;
    assign free_bank     = bank_reg;

    assign rd_en   = (q_pop && (q_dout.kind == car_pkg::KIND_KEPT)) || (xfer && !end_of_clause);
    assign rd_addr = q_pop ? {q_dout.bank, IW'(0)} : {bank_reg, idx_reg + IW'(1)};

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_addr] <= buf_data;
        end
        if (rd_en) begin
            lit_reg <= buf_mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    state_next = B_SEND;
                end
            end
            B_SEND: begin
                if (free_valid) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg  <= q_dout.kind;
            count_reg <= q_dout.count;
            bank_reg  <= q_dout.bank;
            idx_reg   <= '0;
        end else if (xfer && !end_of_clause) begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    a_clause_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        free_valid |=> (state_reg == B_IDLE))
        else $error("emitter did not return to idle after clause end");

endmodule

`default_nettype wire

FILE: hdl/clause_assignment_reducer_core.sv
// ----------------------------------------------------------------------------
// clause_assignment_reducer_core
// Flow: a clause's last literal is registered in the front end, queued as a
// descriptor and popped by the emitter, which registers the first result.
// Throughput: one input per cycle while a clause buffer bank is free; kept literals
// leave one per cycle while m_tready is high, the emitter idling between clauses.
// Reset: a clearing pass of NUM_VARS cycles over the assignment store runs
// after reset and after every 16th clear; s_tready is low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module clause_assignment_reducer_core #(
    parameter int NUM_VARS       = 1024,
    parameter int MAX_CLAUSE_LEN = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [car_pkg::TDATA_W-1:0]  s_tdata,  // [9:0] variable, [10] polarity
    input  wire  [1:0]                   s_tuser,  // [1:0] action
    input  wire                          s_tlast,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [car_pkg::TDATA_W-1:0]  m_tdata,  // [9:0] out_variable, [10] out_polarity
    output logic [1:0]                   m_tuser,  // [1:0] kind
    output logic                         m_tlast
);

    localparam int IW = $clog2(MAX_CLAUSE_LEN);

    logic                        buf_we;
    logic [IW:0]                 buf_addr;
    logic [car_pkg::LIT_W-1:0]   buf_data;
    logic                        push, q_pop, q_empty, q_full;
    car_pkg::car_desc_t          desc, q_dout;
    logic                        free_valid, free_bank;
    logic [car_pkg::VAR_W-1:0]   out_variable;
    logic                        out_polarity;

    car_front #(
        .NUM_VARS       (NUM_VARS),
        .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN),
        .IW             (IW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .action     (s_tuser),
        .variable   (s_tdata[car_pkg::VAR_W-1:0]),
        .polarity   (s_tdata[car_pkg::VAR_W]),
        .last       (s_tlast),
        .buf_we     (buf_we),
        .buf_addr   (buf_addr),
        .buf_data   (buf_data),
        .push       (push),
        .desc       (desc),
        .free_valid (free_valid),
        .free_bank  (free_bank)
    );

    car_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (desc),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty),
        .full    (q_full)
    );

    car_back #(
        .MAX_CLAUSE_LEN (MAX_CLAUSE_LEN),
        .IW             (IW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .buf_we        (buf_we),
        .buf_addr      (buf_addr),
        .buf_data      (buf_data),
        .q_dout        (q_dout),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .free_valid    (free_valid),
        .free_bank     (free_bank),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .kind          (m_tuser),
        .out_variable  (out_variable),
        .out_polarity  (out_polarity),
        .end_of_clause (m_tlast)
    );

    assign m_tdata = {{(car_pkg::TDATA_W - car_pkg::LIT_W){1'b0}}, out_polarity, out_variable};

    a_queue_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("descriptor pushed into a full queue");

endmodule

`default_nettype wire
